[sv/ile_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 3;
    localparam int FOUND_W  = 8;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_INSERT_AT  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_REMOVE_AT  = 3'd5,
        CMD_SEARCH     = 3'd6,
        CMD_READ_AT    = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADIDX   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECIDE,
        OP_CHECK,
        OP_FETCH,
        OP_STORE,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic direct;
        logic loop_done;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

[sv/ile_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ile_ctrl
// Sequencer that steps the datapath through one command at a time.
// ----------------------------------------------------------------------------
module ile_ctrl
    import ile_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t dp_status,
    output op_t             op
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CHECK,
        S_FETCH,
        S_STORE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                op         = OP_DECIDE;
                state_next = dp_status.direct ? S_FINISH : S_CHECK;
            end
            S_CHECK: begin
                op         = OP_CHECK;
                state_next = dp_status.loop_done ? S_FINISH : S_FETCH;
            end
            S_FETCH: begin
                op         = OP_FETCH;
                state_next = S_STORE;
            end
            S_STORE: begin
                op         = OP_STORE;
                state_next = dp_status.hit ? S_FINISH : S_CHECK;
            end
            S_FINISH: begin
                if (dp_status.out_free) begin
                    op         = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[sv/ile_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ile_dp
// Element store, count, walk index and result registers of the list engine.
// ----------------------------------------------------------------------------
module ile_dp
    import ile_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire op_t                      op,
    input  wire logic [CMD_W-1:0]         in_command,
    input  wire logic signed [WORD_W-1:0] in_value,
    input  wire logic [POS_W-1:0]         in_position,
    input  wire logic                     out_ready,
    output dp_status_t                    dp_status,
    output logic                          out_valid,
    output logic [STAT_W-1:0]             out_status,
    output logic [FOUND_W-1:0]            out_found_index,
    output logic signed [WORD_W-1:0]      out_read_value,
    output logic [COUNT_W-1:0]            out_count
);

    typedef enum logic [2:0] {
        K_NONE,
        K_INSERT,
        K_REMOVE,
        K_SEARCH,
        K_READ
    } kind_t;

    logic signed [WORD_W-1:0] mem [CAPACITY];

    cmd_t                     cmd_reg;
    logic signed [WORD_W-1:0] val_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         tpos_reg;
    kind_t                    kind_reg;
    logic signed [WORD_W-1:0] rd_data_reg;
    status_t                  res_status_reg;
    logic [FOUND_W-1:0]       res_found_reg;
    logic signed [WORD_W-1:0] res_readv_reg;
    logic                     out_valid_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic [FOUND_W-1:0]       out_found_reg;
    logic signed [WORD_W-1:0] out_readv_reg;
    logic [COUNT_W-1:0]       out_count_reg;

    kind_t            dec_kind;
    status_t          dec_status;
    logic [CNT_W-1:0] dec_tpos;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             is_full;
    logic             is_empty;
    logic [CNT_W:0]   idx_inc;
    logic [CNT_W-1:0] fetch_addr;
    logic             loop_done;
    logic             hit;

    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        dec_kind   = K_NONE;
        dec_status = ST_OK;
        dec_tpos   = CNT_W'(pos_reg[IDX_W-1:0]);
        unique case (cmd_reg)
            CMD_PUSH_FRONT: begin
                dec_tpos = '0;
                if (is_full) dec_status = ST_FULL;
                else         dec_kind   = K_INSERT;
            end
            CMD_PUSH_BACK: begin
                dec_tpos = count_reg;
                if (is_full) dec_status = ST_FULL;
                else         dec_kind   = K_INSERT;
            end
            CMD_INSERT_AT: begin
                if (pos_ext > cnt_ext) dec_status = ST_BADIDX;
                else if (is_full)      dec_status = ST_FULL;
                else                   dec_kind   = K_INSERT;
            end
            CMD_POP_FRONT: begin
                dec_tpos = '0;
                if (is_empty) dec_status = ST_EMPTY;
                else          dec_kind   = K_REMOVE;
            end
            CMD_POP_BACK: begin
                dec_tpos = count_reg - CNT_W'(1);
                if (is_empty) dec_status = ST_EMPTY;
                else          dec_kind   = K_REMOVE;
            end
            CMD_REMOVE_AT: begin
                if (pos_ext >= cnt_ext) dec_status = ST_BADIDX;
                else                    dec_kind   = K_REMOVE;
            end
            CMD_SEARCH: begin
                dec_kind = K_SEARCH;
            end
            CMD_READ_AT: begin
                if (pos_ext >= cnt_ext) dec_status = ST_BADIDX;
                else                    dec_kind   = K_READ;
            end
            default: dec_status = ST_OK;
        endcase
    end

    assign idx_inc = {1'b0, idx_reg} + (CNT_W + 1)'(1);

    always_comb begin
        loop_done  = 1'b0;
        fetch_addr = idx_reg;
        case (kind_reg)
            K_INSERT: begin
                loop_done  = (idx_reg == tpos_reg);
                fetch_addr = idx_reg - CNT_W'(1);
            end
            K_REMOVE: begin
                loop_done  = (idx_inc >= {1'b0, count_reg});
                fetch_addr = idx_inc[CNT_W-1:0];
            end
            K_SEARCH: loop_done = (idx_reg >= count_reg);
            default:  loop_done = 1'b0;
        endcase
    end

    assign hit = ((kind_reg == K_SEARCH) && (rd_data_reg == val_reg)) ||
                 (kind_reg == K_READ);

    assign dp_status.direct    = (dec_kind == K_NONE);
    assign dp_status.loop_done = loop_done;
    assign dp_status.hit       = hit;
    assign dp_status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (op == OP_CHECK && loop_done && kind_reg == K_INSERT) begin
            mem[tpos_reg[IDX_W-1:0]] <= val_reg;
        end else if (op == OP_STORE &&
                     (kind_reg == K_INSERT || kind_reg == K_REMOVE)) begin
            mem[idx_reg[IDX_W-1:0]] <= rd_data_reg;
        end
        if (op == OP_FETCH) begin
            rd_data_reg <= mem[fetch_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (op == OP_CHECK && loop_done) begin
                if (kind_reg == K_INSERT) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else if (kind_reg == K_REMOVE) begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (op == OP_FINISH) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                cmd_reg <= cmd_t'(in_command);
                val_reg <= in_value;
                pos_reg <= in_position;
            end
            OP_DECIDE: begin
                kind_reg       <= dec_kind;
                tpos_reg       <= dec_tpos;
                res_status_reg <= dec_status;
                res_found_reg  <= '0;
                res_readv_reg  <= '0;
                if (dec_kind == K_INSERT)      idx_reg <= count_reg;
                else if (dec_kind == K_SEARCH) idx_reg <= '0;
                else                           idx_reg <= dec_tpos;
            end
            OP_CHECK: begin
                if (loop_done && kind_reg == K_SEARCH) begin
                    res_status_reg <= ST_NOTFOUND;
                end
            end
            OP_STORE: begin
                case (kind_reg)
                    K_INSERT: idx_reg <= idx_reg - CNT_W'(1);
                    K_REMOVE: idx_reg <= idx_inc[CNT_W-1:0];
                    K_SEARCH: begin
                        if (hit) res_found_reg <= FOUND_W'(idx_reg[IDX_W-1:0]);
                        else     idx_reg       <= idx_inc[CNT_W-1:0];
                    end
                    default: res_readv_reg <= rd_data_reg;
                endcase
            end
            OP_FINISH: begin
                out_status_reg <= res_status_reg;
                out_found_reg  <= res_found_reg;
                out_readv_reg  <= res_readv_reg;
                out_count_reg  <= COUNT_W'(count_reg);
            end
            default: begin
                cmd_reg <= cmd_reg;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_found_index = out_found_reg;
    assign out_read_value  = out_readv_reg;
    assign out_count       = out_count_reg;

endmodule
`default_nettype wire

[sv/indexed_list_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of signed 32-bit words with indexed commands.
// ----------------------------------------------------------------------------
// The engine handles one command at a time and returns one result
// transaction per command. A command that is rejected goes from the decide
// step straight to finishing. Insert and remove move the entries behind the
// target one place per check, fetch and store pass through the single-port
// element store. Search compares one entry per such pass. A command can also
// wait in its finishing step while the previous result still waits on the
// master side. The next command is accepted while a finished result still
// waits on the master side.
module indexed_list_engine
    import ile_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[2:0], value[34:3], position[42:35], zero fill [47:43]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], found_index[10:3], read_value[42:11], count[47:43]
    output logic [47:0]      m_tdata
);

    op_t                      op;
    dp_status_t               dp_status;
    logic [STAT_W-1:0]        out_status;
    logic [FOUND_W-1:0]       out_found_index;
    logic signed [WORD_W-1:0] out_read_value;
    logic [COUNT_W-1:0]       out_count;

    ile_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .op        (op)
    );

    ile_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op              (op),
        .in_command      (s_tdata[2:0]),
        .in_value        (s_tdata[34:3]),
        .in_position     (s_tdata[42:35]),
        .out_ready       (m_tready),
        .dp_status       (dp_status),
        .out_valid       (m_tvalid),
        .out_status      (out_status),
        .out_found_index (out_found_index),
        .out_read_value  (out_read_value),
        .out_count       (out_count)
    );

    assign m_tdata = {out_count, out_read_value, out_found_index, out_status};

endmodule
`default_nettype wire

[sim/list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker
// Watches both streams of the indexed list engine and checks every result.
// ----------------------------------------------------------------------------
// Each accepted command is applied to a shadow copy of the list, and the
// result that it should produce is queued. Each result transaction is
// compared field by field with the oldest queued result. Mismatches are
// reported one line each and counted for the testbench top.
module list_checker
    import ile_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    output int               mismatches,
    output int               outstanding,
    output int               checked,
    output logic [4:0]       status_seen
);

    typedef struct packed {
        status_t              status;
        logic [FOUND_W-1:0]   found_index;
        logic [WORD_W-1:0]    read_value;
        logic [COUNT_W-1:0]   count;
    } list_result_t;

    logic [WORD_W-1:0] shadow_list[$];
    list_result_t      pending_results[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
        status_seen = '0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic list_result_t apply_command(input cmd_t op,
                                                   input logic [WORD_W-1:0] word,
                                                   input logic [POS_W-1:0] pos);
        list_result_t r;
        int held;
        int slot;
        held          = shadow_list.size();
        r.status      = ST_OK;
        r.found_index = '0;
        r.read_value  = '0;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
                if (op == CMD_INSERT_AT && pos > held) begin
                    r.status = ST_BADIDX;
                end else if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (op == CMD_PUSH_FRONT) begin
                    shadow_list.push_front(word);
                end else if (op == CMD_PUSH_BACK) begin
                    shadow_list.push_back(word);
                end else begin
                    shadow_list.insert(pos, word);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (op == CMD_POP_FRONT) begin
                    shadow_list.delete(0);
                end else begin
                    shadow_list.delete(held - 1);
                end
            end
            CMD_REMOVE_AT: begin
                if (pos >= held) begin
                    r.status = ST_BADIDX;
                end else begin
                    shadow_list.delete(pos);
                end
            end
            CMD_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (slot = 0; slot < held; slot++) begin
                    if (r.status == ST_NOTFOUND && shadow_list[slot] == word) begin
                        r.status      = ST_OK;
                        r.found_index = FOUND_W'(slot);
                    end
                end
            end
            default: begin
                if (pos >= held) begin
                    r.status = ST_BADIDX;
                end else begin
                    r.read_value = shadow_list[pos];
                end
            end
        endcase
        r.count = COUNT_W'(shadow_list.size());
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        list_result_t want;
        if (!aresetn) begin
            shadow_list.delete();
            pending_results.delete();
        end else begin
            // A result leaving in the same cycle as a command arrives always
            // belongs to an earlier command, so it is checked first.
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with no command waiting",
                                    m_tdata[31:0], 32'h0);
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    status_seen[want.status] = 1'b1;
                    if (m_tdata[2:0] !== want.status)
                        report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
                    if (m_tdata[10:3] !== want.found_index)
                        report_mismatch("found_index", 32'(m_tdata[10:3]),
                                        32'(want.found_index));
                    if (m_tdata[42:11] !== want.read_value)
                        report_mismatch("read_value", m_tdata[42:11], want.read_value);
                    if (m_tdata[47:43] !== want.count)
                        report_mismatch("count", 32'(m_tdata[47:43]), 32'(want.count));
                end
            end
            if (s_tvalid && s_tready) begin
                pending_results.push_back(apply_command(cmd_t'(s_tdata[2:0]),
                                                        s_tdata[34:3], s_tdata[42:35]));
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the indexed list engine.
// ----------------------------------------------------------------------------
// A short directed sequence covers the empty list, bad indexes on every
// indexed command, the tail insert, duplicate search and the extreme words.
// Random commands then follow in four phases of sender and receiver idling,
// leaning in turn toward filling and draining the list so that the full
// cases are reached often. Once the receiver holds off for a long stretch
// while commands keep coming. A separate checker predicts and compares.
module tb_top;
    import ile_pkg::*;

    localparam int QUIET_LIMIT    = 3000;
    localparam int TAIL_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 150;
    localparam int HOLD_OFF_LEN   = 400;

    typedef enum int {
        LEAN_FILL,
        LEAN_DRAIN,
        LEAN_MIXED
    } lean_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;

    int          mismatches;
    int          outstanding;
    int          checked;
    logic [4:0]  status_seen;

    int          send_idle   = 0;
    int          stall_pct   = 0;
    int          hold_cycles = 0;
    int          sent_total  = 0;
    logic [31:0] word_pool[8];

    indexed_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .status_seen (status_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_command(input cmd_t op, input logic [31:0] word,
                                input logic [7:0] pos);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, pos, word, op};
        do @(posedge aclk); while (!s_tready);
        sent_total++;
    endtask

    task automatic send_random(input lean_t lean);
        cmd_t        op;
        logic [31:0] word;
        logic [7:0]  pos;
        int          pick;
        pick = $urandom_range(99);
        case (lean)
            LEAN_FILL:  op = (pick < 70) ? cmd_t'($urandom_range(2, 0))
                                         : cmd_t'($urandom_range(7, 0));
            LEAN_DRAIN: op = (pick < 70) ? cmd_t'($urandom_range(5, 3))
                                         : cmd_t'($urandom_range(7, 0));
            default:    op = cmd_t'($urandom_range(7, 0));
        endcase
        word = ($urandom_range(3) == 0) ? $urandom : word_pool[$urandom_range(7)];
        pos  = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                        : 8'($urandom_range(CAPACITY + 1));
        send_command(op, word, pos);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin : stimulus
        int    phase;
        int    n;
        lean_t lean;

        word_pool[0] = 32'h8000_0000;
        word_pool[1] = 32'h7FFF_FFFF;
        word_pool[2] = 32'h0000_0000;
        word_pool[3] = 32'hFFFF_FFFF;
        for (n = 4; n < 8; n++)
            word_pool[n] = $urandom;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty list: pops, indexed commands and search all fail.
        send_command(CMD_POP_FRONT, 32'h0, 8'd0);
        send_command(CMD_POP_BACK,  32'h0, 8'd0);
        send_command(CMD_REMOVE_AT, 32'h0, 8'd0);
        send_command(CMD_READ_AT,   32'h0, 8'd0);
        send_command(CMD_SEARCH,    32'h0, 8'd0);
        send_command(CMD_INSERT_AT, 32'h1234_5678, 8'd1);
        // Build a short list with the extreme words and a duplicate.
        send_command(CMD_INSERT_AT,  32'h8000_0000, 8'd0);
        send_command(CMD_PUSH_BACK,  32'h7FFF_FFFF, 8'd0);
        send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 8'd0);
        send_command(CMD_INSERT_AT,  32'h0000_0000, 8'd3);
        send_command(CMD_INSERT_AT,  32'h7FFF_FFFF, 8'd1);
        send_command(CMD_SEARCH,     32'h7FFF_FFFF, 8'd0);
        send_command(CMD_READ_AT,    32'h0, 8'd4);
        send_command(CMD_READ_AT,    32'h0, 8'd5);
        send_command(CMD_READ_AT,    32'h0, 8'd255);
        send_command(CMD_REMOVE_AT,  32'h0, 8'd255);
        send_command(CMD_INSERT_AT,  32'h5555_AAAA, 8'd255);
        send_command(CMD_REMOVE_AT,  32'h0, 8'd2);
        send_command(CMD_POP_FRONT,  32'h0, 8'd0);
        send_command(CMD_POP_BACK,   32'h0, 8'd0);
        send_command(CMD_SEARCH,     32'h5A5A_5A5A, 8'd0);
        wait_drained();

        lean = LEAN_FILL;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle = 0;  stall_pct = 0;  end
                1:       begin send_idle = 72; stall_pct = 0;  end
                2:       begin send_idle = 0;  stall_pct = 72; end
                default: begin send_idle = 35; stall_pct = 35; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 30 == 0)
                    lean = (n == 0) ? LEAN_FILL : lean_t'($urandom_range(2));
                send_random(lean);
            end
            if (phase == 0) begin
                // The receiver holds off while commands keep coming, so the
                // engine backs up and stalls its input.
                hold_cycles = HOLD_OFF_LEN;
                repeat (12) send_random(LEAN_MIXED);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Drove %0d list commands over four idling phases and one long hold-off;",
                 sent_total);
        $display("checked %0d results, status codes seen (one bit per code): %b",
                 checked, status_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
